### rtl/assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: pre holds, so post holds in this cycle.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication: pre holds, so post holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

### rtl/prma_pkg.sv
package prma_pkg;

  // Field widths
  localparam int PIXEL_W     = 24;
  localparam int INDEX_W     = 22;
  localparam int CFG_DIM_W   = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIXEL_W - INDEX_W;

  typedef logic [PIXEL_W-1:0]     pixel_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [CFG_DIM_W-1:0]   dim_cfg_t;
  typedef logic [CFG_INDEX_W-1:0] reg_index_t;
  typedef logic [1:0]             turn_t;

  // Register indexes
  localparam reg_index_t REG_SOURCE_WIDTH      = 3'd0;
  localparam reg_index_t REG_SOURCE_HEIGHT     = 3'd1;
  localparam reg_index_t REG_QUARTER_TURNS     = 3'd2;
  localparam reg_index_t REG_MIRROR_HORIZONTAL = 3'd3;
  localparam reg_index_t REG_MIRROR_VERTICAL   = 3'd4;

  // Clockwise rotation codes
  localparam turn_t TURN_NONE = 2'd0;
  localparam turn_t TURN_90   = 2'd1;
  localparam turn_t TURN_180  = 2'd2;
  localparam turn_t TURN_270  = 2'd3;

  // Register reset values
  localparam dim_cfg_t WIDTH_RESET  = 12'd1280;
  localparam dim_cfg_t HEIGHT_RESET = 12'd720;

endpackage

### rtl/pixel_rotate_mirror_addresser_core.sv
// An input transfer passes through the first-stage register and then the output register.
// Throughput: one pixel per clock unless m_tready stalls the output; the address path is a rotate/mirror stage
// followed by one row-times-width multiply-add stage.
// Reset (rst, synchronous): clears both pipeline stages and the column/row
// counters, and loads the registers with 1280 x 720, no rotation, no mirror.
`include "assert_macros.svh"

module pixel_rotate_mirror_addresser_core #(
  parameter int MAX_DIM = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [prma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [prma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prma_pkg::PIXEL_W-1:0]     s_tdata,   // [23:0] pixel_value
  input  logic                             s_tuser,   // [0] frame_start
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prma_pkg::OUT_TDATA_W-1:0] m_tdata,   // [23:0] pixel_out, [45:24] dest_index
  output logic                             m_tlast    // frame_last
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = CW + 1;
  localparam int CMPW = (DW > prma_pkg::CFG_DIM_W) ? DW : prma_pkg::CFG_DIM_W;
  localparam int PW   = (CW + DW + 1 > prma_pkg::INDEX_W) ? CW + DW + 1 : prma_pkg::INDEX_W;

  // Configuration registers
  prma_pkg::dim_cfg_t source_width;
  prma_pkg::dim_cfg_t source_height;
  prma_pkg::turn_t    quarter_turns;
  logic               mirror_horizontal;
  logic               mirror_vertical;

  // Source position counters
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;

  // Combinational address logic
  logic [DW-1:0] w_eff, h_eff, w_m1, h_m1;
  logic [CW-1:0] col_cur, row_cur, x, y;
  logic          col_end, row_end, last_c;
  logic [DW-1:0] rot_ow, rot_oh, oh_m1, ow_m1;
  logic [CW-1:0] rot_ox, rot_oy, mir_ox, mir_oy;

  // First stage
  logic              s1_valid;
  prma_pkg::pixel_t  s1_pixel;
  logic [CW-1:0]     s1_ox;
  logic [CW-1:0]     s1_oy;
  logic [DW-1:0]     s1_ow;
  logic              s1_last;

  // Output stage
  prma_pkg::pixel_t  m_pixel;
  prma_pkg::index_t  m_index;
  logic [PW-1:0]     index_full;

  logic accept, out_free, s1_move;

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width      <= prma_pkg::WIDTH_RESET;
      source_height     <= prma_pkg::HEIGHT_RESET;
      quarter_turns     <= prma_pkg::TURN_NONE;
      mirror_horizontal <= 1'b0;
      mirror_vertical   <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        prma_pkg::REG_SOURCE_WIDTH:      source_width      <= cfg_data;
        prma_pkg::REG_SOURCE_HEIGHT:     source_height     <= cfg_data;
        prma_pkg::REG_QUARTER_TURNS:     quarter_turns     <= cfg_data[1:0];
        prma_pkg::REG_MIRROR_HORIZONTAL: mirror_horizontal <= cfg_data[0];
        prma_pkg::REG_MIRROR_VERTICAL:   mirror_vertical   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero reads as one, oversize as the maximum
  always_comb begin
    if (source_width == '0) begin
      w_eff = DW'(1);
    end else if (CMPW'(source_width) > CMPW'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(source_width);
    end
    if (source_height == '0) begin
      h_eff = DW'(1);
    end else if (CMPW'(source_height) > CMPW'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(source_height);
    end
    w_m1 = w_eff - DW'(1);
    h_m1 = h_eff - DW'(1);
  end

  // Current source position; frame start and stale counters fall back to origin
  always_comb begin
    col_cur = s_tuser ? '0 : column_count;
    row_cur = s_tuser ? '0 : row_count;
    x       = (DW'(col_cur) < w_eff) ? col_cur : '0;
    y       = (DW'(row_cur) < h_eff) ? row_cur : '0;
    col_end = (DW'(x) == w_m1);
    row_end = (DW'(y) == h_m1);
    last_c  = col_end && row_end;
  end

  // Advance the raster counters
  always_comb begin
    if (last_c) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (col_end) begin
      column_count_next = '0;
      row_count_next    = y + CW'(1);
    end else begin
      column_count_next = x + CW'(1);
      row_count_next    = y;
    end
  end

  // Rotate clockwise, then mirror in output coordinates
  always_comb begin
    case (quarter_turns)
      prma_pkg::TURN_90: begin
        rot_ow = h_eff;
        rot_oh = w_eff;
        rot_ox = CW'(h_m1 - DW'(y));
        rot_oy = x;
      end
      prma_pkg::TURN_180: begin
        rot_ow = w_eff;
        rot_oh = h_eff;
        rot_ox = CW'(w_m1 - DW'(x));
        rot_oy = CW'(h_m1 - DW'(y));
      end
      prma_pkg::TURN_270: begin
        rot_ow = h_eff;
        rot_oh = w_eff;
        rot_ox = y;
        rot_oy = CW'(w_m1 - DW'(x));
      end
      default: begin
        rot_ow = w_eff;
        rot_oh = h_eff;
        rot_ox = x;
        rot_oy = y;
      end
    endcase
    ow_m1  = rot_ow - DW'(1);
    oh_m1  = rot_oh - DW'(1);
    mir_ox = mirror_horizontal ? CW'(ow_m1 - DW'(rot_ox)) : rot_ox;
    mir_oy = mirror_vertical ? CW'(oh_m1 - DW'(rot_oy)) : rot_oy;
  end

  // Hold the counters between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // First stage: output coordinates and width
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= s_tdata;
      s1_ox    <= mir_ox;
      s1_oy    <= mir_oy;
      s1_ow    <= rot_ow;
      s1_last  <= last_c;
    end
  end

  // Linear index: row times output width plus column, kept to the index width
  assign index_full = PW'(s1_oy) * PW'(s1_ow) + PW'(s1_ox);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_pixel <= s1_pixel;
      m_index <= index_full[prma_pkg::INDEX_W-1:0];
      m_tlast <= s1_last;
    end
  end

  assign m_tdata = {{prma_pkg::OUT_PAD_W{1'b0}}, m_index, m_pixel};

  // Checks
  `ASSERT_IMPLIES(a_col_in_range, clk, rst, s1_valid, DW'(s1_ox) < s1_ow, "output column beyond output width")
  `ASSERT_NEXT(a_wrap_on_last, clk, rst, accept && last_c, (column_count == '0) && (row_count == '0), "counters did not wrap after last pixel")
  `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready && s1_valid, !s_tready, "input taken while both stages are full")
  `ASSERT_NEXT(a_stage_drains, clk, rst, s1_valid && !m_tvalid, m_tvalid, "first stage did not move into empty output register")

endmodule

### test/tb_pixel_rotate_mirror_addresser_core.sv
`timescale 1ns / 1ps

module tb_pixel_rotate_mirror_addresser_core;
  import prma_pkg::*;

  localparam int MAX_DIM = 2048;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 80;
  localparam int TAIL_CYCLES = 6;
  localparam int PIXEL_TARGET = 1750;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    pixel_t pixel;
    index_t index;
    logic   last;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  reg_index_t            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  pixel_t                s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Register copies and raster position of the address predictor
  dim_cfg_t    width_reg;
  dim_cfg_t    height_reg;
  turn_t       turns_reg;
  logic        mirror_h_reg;
  logic        mirror_v_reg;
  int unsigned column_pos;
  int unsigned row_pos;

  placement_t expected_placements[$];
  int         mismatches = 0;
  int         pixels_sent = 0;
  int         idle_cycles = 0;
  bit         sender_quiet = 1'b0;
  bit         receiver_quiet = 1'b0;
  bit         hold_request = 1'b0;

  pixel_rotate_mirror_addresser_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned effective_dim(int unsigned value);
    if (value == 0) return 1;
    if (value > MAX_DIM) return MAX_DIM;
    return value;
  endfunction

  // Rotate then mirror the current raster position, and advance the counters
  function automatic placement_t place_pixel(pixel_t pixel, logic first);
    int unsigned w, h, x, y, ox, oy, ow, oh;
    placement_t  p;
    w = effective_dim(width_reg);
    h = effective_dim(height_reg);
    if (first) begin
      column_pos = 0;
      row_pos = 0;
    end
    // a counter left outside a shrunken frame restarts at the origin
    x = (column_pos < w) ? column_pos : 0;
    y = (row_pos < h) ? row_pos : 0;
    case (turns_reg)
      TURN_90: begin
        ow = h; oh = w; ox = h - 1 - y; oy = x;
      end
      TURN_180: begin
        ow = w; oh = h; ox = w - 1 - x; oy = h - 1 - y;
      end
      TURN_270: begin
        ow = h; oh = w; ox = y; oy = w - 1 - x;
      end
      default: begin
        ow = w; oh = h; ox = x; oy = y;
      end
    endcase
    if (mirror_v_reg) oy = oh - 1 - oy;
    if (mirror_h_reg) ox = ow - 1 - ox;
    p.pixel = pixel;
    p.index = index_t'(oy * ow + ox);
    p.last = (x == w - 1) && (y == h - 1);
    if (p.last) begin
      column_pos = 0;
      row_pos = 0;
    end else if (x == w - 1) begin
      column_pos = 0;
      row_pos = y + 1;
    end else begin
      column_pos = x + 1;
      row_pos = y;
    end
    return p;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Track register writes, predict each input transfer, check each output transfer
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      turns_reg = TURN_NONE;
      mirror_h_reg = 1'b0;
      mirror_v_reg = 1'b0;
      column_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:      width_reg = cfg_data;
          REG_SOURCE_HEIGHT:     height_reg = cfg_data;
          REG_QUARTER_TURNS:     turns_reg = turn_t'(cfg_data);
          REG_MIRROR_HORIZONTAL: mirror_h_reg = cfg_data[0];
          REG_MIRROR_VERTICAL:   mirror_v_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_placements.push_back(place_pixel(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (expected_placements.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: tdata 0x%0h tlast %0b", m_tdata, m_tlast);
        end else begin
          want = expected_placements.pop_front();
          check_field("pixel_out", want.pixel, m_tdata[PIXEL_W-1:0]);
          check_field("dest_index", want.index, m_tdata[PIXEL_W +: INDEX_W]);
          check_field("frame_last", want.last, m_tlast);
        end
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls before each transfer, plus an occasional long hold
  initial begin
    int stall;
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = receiver_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff m_tvalid);
    end
  end

  // Offer one pixel after a random gap and hold it until the transfer
  task automatic send_pixel(pixel_t pixel, logic first);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pixel;
    s_tuser <= first;
    @(posedge clk iff s_tready);
    pixels_sent++;
  endtask

  // Send count pixels in raster order with frame start on the first pixel
  task automatic send_frame(int count);
    for (int i = 0; i < count; i++)
      send_pixel(pixel_t'($urandom), i == 0);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    s_tuser <= 1'b0;
    @(posedge clk);
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t index, int unsigned value);
    cfg_wen <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Write all registers, and the unused indexes when asked; narrow registers get random upper bits
  task automatic apply_settings(int unsigned width, int unsigned height, turn_t turns,
                                logic mirror_h, logic mirror_v, bit with_unused);
    int unsigned noise;
    noise = $urandom_range(0, 2**CFG_DATA_W - 1);
    write_reg(REG_SOURCE_WIDTH, width);
    write_reg(REG_SOURCE_HEIGHT, height);
    write_reg(REG_QUARTER_TURNS, (noise & ~32'h3) | turns);
    write_reg(REG_MIRROR_HORIZONTAL, (noise & ~32'h1) | mirror_h);
    write_reg(REG_MIRROR_VERTICAL, (noise & ~32'h1) | mirror_v);
    if (with_unused)
      for (int i = REG_MIRROR_VERTICAL + 1; i < 2**CFG_INDEX_W; i++)
        write_reg(reg_index_t'(i), $urandom_range(0, 2**CFG_DATA_W - 1));
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Reset geometry 1280 x 720, pixel extremes
  task automatic test_reset_geometry();
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b0);
    send_pixel(pixel_t'($urandom), 1'b0);
    wait_idle();
  endtask

  // Every turn on a non-square frame, each with a different mirror combination
  task automatic test_quarter_turns();
    turn_t turns;
    for (int t = 0; t < 4; t++) begin
      turns = turn_t'(t);
      apply_settings(3, 2, turns, turns[0], turns[1], 1'b0);
      send_frame(6);
      wait_idle();
    end
  endtask

  // Zero and oversized dimensions, and the largest frame
  task automatic test_dimension_limits();
    apply_settings(0, 0, TURN_NONE, 1'b0, 1'b0, 1'b0);
    send_frame(2);
    wait_idle();
    apply_settings(2**CFG_DIM_W - 1, MAX_DIM + 1, TURN_180, 1'b0, 1'b0, 1'b0);
    send_frame(2);
    wait_idle();
    apply_settings(MAX_DIM, MAX_DIM, TURN_90, 1'b1, 1'b0, 1'b0);
    send_frame(2);
    wait_idle();
  endtask

  // Shrink the frame under counters left mid-frame
  task automatic test_stale_counters();
    apply_settings(4, 4, TURN_NONE, 1'b0, 1'b0, 1'b0);
    send_frame(3);
    wait_idle();
    apply_settings(2, 4, TURN_NONE, 1'b0, 1'b0, 1'b0);
    send_pixel(pixel_t'($urandom), 1'b0);
    send_pixel(pixel_t'($urandom), 1'b0);
    wait_idle();
    apply_settings(1, 4, TURN_NONE, 1'b0, 1'b0, 1'b0);
    send_frame(3);
    wait_idle();
    apply_settings(1, 2, TURN_270, 1'b0, 1'b0, 1'b0);
    send_pixel(pixel_t'($urandom), 1'b0);
    wait_idle();
  endtask

  // Writes to unused indexes must leave the settings alone
  task automatic test_unused_registers();
    apply_settings(5, 3, TURN_270, 1'b0, 1'b1, 1'b1);
    send_frame(4);
    wait_idle();
  endtask

  // Frame start in the middle of a frame resynchronises the counters
  task automatic test_frame_restart();
    apply_settings(4, 3, TURN_90, 1'b1, 1'b1, 1'b0);
    send_frame(5);
    send_frame(3);
    wait_idle();
  endtask

  // Hold the output off while the input keeps offering pixels
  task automatic test_output_stall();
    apply_settings(6, 5, TURN_180, 1'b0, 1'b0, 1'b0);
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    send_frame(60);
    sender_quiet = 1'b0;
    wait_idle();
  endtask

  // Random settings; mostly whole frames, some cut short, without frame start or with random frame starts
  task automatic test_random_frames();
    bit          big;
    int unsigned width, height;
    int          frame_size, frames, kind, count;
    logic        first;
    while (pixels_sent < PIXEL_TARGET) begin
      big = ($urandom_range(0, 9) == 0);
      width = big ? $urandom_range(0, 2**CFG_DIM_W - 1) : $urandom_range(0, 12);
      height = big ? $urandom_range(0, 2**CFG_DIM_W - 1) : $urandom_range(0, 12);
      apply_settings(width, height, turn_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 7) == 0);
      sender_quiet = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      frame_size = effective_dim(width) * effective_dim(height);
      if (frame_size > 64) frame_size = $urandom_range(32, 64);
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        kind = $urandom_range(0, 9);
        count = (kind == 8) ? $urandom_range(1, frame_size) : frame_size;
        for (int i = 0; i < count; i++) begin
          first = (i == 0) && (kind != 7);
          if (kind == 9) first = ($urandom_range(0, 7) == 0);
          send_pixel(pixel_t'($urandom), first);
        end
      end
      wait_idle();
    end
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_quarter_turns();
    test_dimension_limits();
    test_stale_counters();
    test_unused_registers();
    test_frame_restart();
    test_output_stall();
    test_random_frames();
    wait_idle();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
